// ===== rtl/core/bmsi_pkg.sv =====
// ----------------------------------------------------------------------------
// bmsi_pkg
// Types and constants shared by the bank mapper with scanline IRQ counter.
// ----------------------------------------------------------------------------
`default_nettype none

package bmsi_pkg;

    localparam int PRG_ADDR_BITS_DEF = 19;
    localparam int CHR_ADDR_BITS_DEF = 18;
    localparam int MAP_ADDR_W        = 19;
    localparam int NUM_BANKS         = 8;

    localparam logic [5:0] PRG_BANK_COUNT_RST = 6'd2;
    localparam logic [3:0] A12_FILTER_MIN     = 4'd9;
    localparam logic [3:0] A12_RUN_MAX        = 4'd15;

    typedef enum logic [1:0] {
        ACT_CPU_WRITE = 2'd0,
        ACT_CPU_READ  = 2'd1,
        ACT_PPU_TICK  = 2'd2,
        ACT_NONE      = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_NONE    = 2'd0,
        REG_PRG_ROM = 2'd1,
        REG_PRG_RAM = 2'd2,
        REG_CHR_ROM = 2'd3
    } t_region;

    typedef enum logic [1:0] {
        WR_BANK   = 2'd0,
        WR_MIRROR = 2'd1,
        WR_IRQ    = 2'd2,
        WR_ENABLE = 2'd3
    } t_wr_group;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic [7:0]  value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]            region;
        logic [MAP_ADDR_W-1:0] mapped_address;
        logic                  irq_pulse;
        logic                  mirror_horizontal;
    } t_out_item;

    typedef struct packed {
        logic [5:0]                 prg_bank_count;
        logic [7:0]                 bank_ctrl;
        logic [NUM_BANKS-1:0][7:0]  banks;
    } t_map_state;

    typedef struct packed {
        logic irq_pulse;
        logic mirror;
    } t_step_status;

endpackage

`default_nettype wire

// ===== rtl/core/bank_mapper_with_scanline_irq_core.sv =====
// ----------------------------------------------------------------------------
// bank_mapper_with_scanline_irq_core
// Cartridge bank mapper: CPU and PPU address translation, mapper registers
// and the A12-clocked scanline IRQ counter.
//
// Channel  Direction  Handshake                   Payload
// in       input      i_in_valid / o_in_ready     i_in_item  (t_in_item)
// out      output     o_out_valid / i_out_ready   o_out_item (t_out_item)
// cfg      input      i_cfg_we                    i_cfg_data (prg_bank_count)
//
// An item is registered on acceptance; its result is registered when the item
// advances, which a stalled output holds off. One item per cycle is sustained
// while the output is not stalled. The mapper state is updated in the same
// cycle that the result register loads. A stalled output holds the input
// register, which keeps accepting while the result register is free or being
// drained. Synchronous reset restores the valid flags and mapper registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bank_mapper_with_scanline_irq_core
    import bmsi_pkg::*;
#(
    parameter int PRG_ADDR_BITS = PRG_ADDR_BITS_DEF,
    parameter int CHR_ADDR_BITS = CHR_ADDR_BITS_DEF
)
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_item   i_in_item,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out_item,
    input  wire logic       i_cfg_we,
    input  wire logic [5:0] i_cfg_data
);

    logic                  r_in_valid;
    t_in_item              r_in_item;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic                  advance;
    t_map_state            map_state;
    t_step_status          status;
    logic [1:0]            region;
    logic [MAP_ADDR_W-1:0] mapped;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    bmsi_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_item     (r_in_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_state    (map_state),
        .o_status   (status)
    );

    bmsi_xlate #(
        .PRG_ADDR_BITS (PRG_ADDR_BITS),
        .CHR_ADDR_BITS (CHR_ADDR_BITS)
    ) u_xlate (
        .i_item   (r_in_item),
        .i_state  (map_state),
        .o_region (region),
        .o_mapped (mapped)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item.region            <= region;
            r_out_item.mapped_address    <= mapped;
            r_out_item.irq_pulse         <= status.irq_pulse;
            r_out_item.mirror_horizontal <= status.mirror;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ===== rtl/core/bmsi_regs.sv =====
// ----------------------------------------------------------------------------
// bmsi_regs
// Mapper register file, A12 edge filter and scanline IRQ counter.
// ----------------------------------------------------------------------------
`default_nettype none

module bmsi_regs
    import bmsi_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_step,
    input  wire t_in_item     i_item,
    input  wire logic         i_cfg_we,
    input  wire logic [5:0]   i_cfg_data,
    output t_map_state        o_state,
    output t_step_status      o_status
);

    logic [5:0]                r_prg_bank_count;
    logic [7:0]                r_bank_ctrl;
    logic [NUM_BANKS-1:0][7:0] r_banks;
    logic                      r_mirror;
    logic [7:0]                r_irq_reload;
    logic [7:0]                r_irq_count;
    logic                      r_irq_on;
    logic [3:0]                r_a12_run;

    logic [7:0]                n_bank_ctrl;
    logic [NUM_BANKS-1:0][7:0] n_banks;
    logic                      n_mirror;
    logic [7:0]                n_irq_reload;
    logic [7:0]                n_irq_count;
    logic                      n_irq_on;
    logic [3:0]                n_a12_run;
    logic                      n_pulse;

    logic [2:0]                bank_idx;
    logic [7:0]                bank_val;
    logic                      odd;

    assign odd      = i_item.address[0];
    assign bank_idx = r_bank_ctrl[2:0];

    always_comb begin
        bank_val = i_item.value;
        if (bank_idx < 3'd2) begin
            bank_val = i_item.value & 8'hfe;
        end else if (bank_idx > 3'd5) begin
            bank_val = i_item.value & 8'h3f;
        end
    end

    always_comb begin
        n_bank_ctrl  = r_bank_ctrl;
        n_banks      = r_banks;
        n_mirror     = r_mirror;
        n_irq_reload = r_irq_reload;
        n_irq_count  = r_irq_count;
        n_irq_on     = r_irq_on;
        n_a12_run    = r_a12_run;
        n_pulse      = 1'b0;
        case (t_action'(i_item.action))
            ACT_CPU_WRITE: begin
                if (i_item.address[15]) begin
                    case (t_wr_group'(i_item.address[14:13]))
                        WR_BANK: begin
                            if (!odd) begin
                                n_bank_ctrl = i_item.value;
                            end else begin
                                n_banks[bank_idx] = bank_val;
                            end
                        end
                        WR_MIRROR: begin
                            if (!odd) begin
                                n_mirror = i_item.value[0];
                            end
                        end
                        WR_IRQ: begin
                            if (!odd) begin
                                n_irq_reload = i_item.value;
                            end else begin
                                n_irq_count = 8'd0;
                            end
                        end
                        WR_ENABLE: begin
                            n_irq_on = odd;
                        end
                        default: begin
                            n_irq_on = r_irq_on;
                        end
                    endcase
                end
            end
            ACT_PPU_TICK: begin
                if (!i_item.address[12]) begin
                    if (r_a12_run != A12_RUN_MAX) begin
                        n_a12_run = r_a12_run + 4'd1;
                    end
                end else begin
                    n_a12_run = 4'd0;
                    if (r_a12_run >= A12_FILTER_MIN) begin
                        if (r_irq_count == 8'd0) begin
                            n_irq_count = r_irq_reload;
                        end else begin
                            n_irq_count = r_irq_count - 8'd1;
                        end
                        n_pulse = (n_irq_count == 8'd0) && r_irq_on;
                    end
                end
            end
            default: begin
                n_pulse = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_bank_count <= PRG_BANK_COUNT_RST;
            r_bank_ctrl      <= '0;
            r_banks          <= '0;
            r_mirror         <= 1'b0;
            r_irq_reload     <= '0;
            r_irq_count      <= '0;
            r_irq_on         <= 1'b0;
            r_a12_run        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_prg_bank_count <= i_cfg_data;
            end
            if (i_step) begin
                r_bank_ctrl  <= n_bank_ctrl;
                r_banks      <= n_banks;
                r_mirror     <= n_mirror;
                r_irq_reload <= n_irq_reload;
                r_irq_count  <= n_irq_count;
                r_irq_on     <= n_irq_on;
                r_a12_run    <= n_a12_run;
            end
        end
    end

    assign o_state.prg_bank_count = r_prg_bank_count;
    assign o_state.bank_ctrl      = r_bank_ctrl;
    assign o_state.banks          = r_banks;
    assign o_status.irq_pulse     = n_pulse;
    assign o_status.mirror        = n_mirror;

endmodule

`default_nettype wire

// ===== rtl/core/bmsi_xlate.sv =====
// ----------------------------------------------------------------------------
// bmsi_xlate
// Translates a CPU or PPU address to a region and a byte offset in it.
// ----------------------------------------------------------------------------
`default_nettype none

module bmsi_xlate
    import bmsi_pkg::*;
#(
    parameter int PRG_ADDR_BITS = PRG_ADDR_BITS_DEF,
    parameter int CHR_ADDR_BITS = CHR_ADDR_BITS_DEF
)
(
    input  wire t_in_item              i_item,
    input  wire t_map_state            i_state,
    output logic [1:0]                 o_region,
    output logic [MAP_ADDR_W-1:0]      o_mapped
);

    localparam int PRG_FULL_W = 21;
    localparam int CHR_FULL_W = 18;

    localparam logic [PRG_FULL_W-1:0] PRG_MASK =
        PRG_FULL_W'((64'd1 << PRG_ADDR_BITS) - 64'd1);
    localparam logic [CHR_FULL_W-1:0] CHR_MASK =
        CHR_FULL_W'((64'd1 << CHR_ADDR_BITS) - 64'd1);

    logic [4:0]            fixed_hi;
    logic [7:0]            prg_bank;
    logic [PRG_FULL_W-1:0] prg_off;
    logic [12:0]           chr_w;
    logic [CHR_FULL_W-1:0] chr_off;
    logic [1:0]            win;

    assign win      = i_item.address[14:13];
    assign fixed_hi = i_state.prg_bank_count[4:0] - 5'd1;

    always_comb begin
        case (win)
            2'd1:    prg_bank = i_state.banks[7];
            2'd3:    prg_bank = {2'b00, fixed_hi, 1'b1};
            default: begin
                if ((win == 2'd0) == (i_state.bank_ctrl[6] == 1'b0)) begin
                    prg_bank = i_state.banks[6];
                end else begin
                    prg_bank = {2'b00, fixed_hi, 1'b0};
                end
            end
        endcase
    end

    assign prg_off = {prg_bank, i_item.address[12:0]} & PRG_MASK;

    assign chr_w = i_item.address[12:0] ^ {i_state.bank_ctrl[7], 12'd0};

    always_comb begin
        if (!chr_w[12]) begin
            chr_off = {i_state.banks[{2'b00, chr_w[11]}][7:1], chr_w[10:0]};
        end else begin
            chr_off = {i_state.banks[{1'b0, chr_w[11:10]} + 3'd2], chr_w[9:0]};
        end
    end

    always_comb begin
        o_region = REG_NONE;
        o_mapped = '0;
        case (t_action'(i_item.action))
            ACT_CPU_WRITE, ACT_CPU_READ: begin
                if (i_item.address[15:13] == 3'b011) begin
                    o_region = REG_PRG_RAM;
                    o_mapped = MAP_ADDR_W'(i_item.address[12:0]);
                end else if (i_item.action == ACT_CPU_READ && i_item.address[15]) begin
                    o_region = REG_PRG_ROM;
                    o_mapped = prg_off[MAP_ADDR_W-1:0];
                end
            end
            ACT_PPU_TICK: begin
                if (!i_item.address[13]) begin
                    o_region = REG_CHR_ROM;
                    o_mapped = MAP_ADDR_W'(chr_off & CHR_MASK);
                end
            end
            default: begin
                o_region = REG_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sim/bmsi_map_checker.sv =====
// ----------------------------------------------------------------------------
// bmsi_map_checker
// Watches the request and result channels of the bank mapper. Every accepted
// request is translated by a local model of the mapper registers, the A12
// filter and the scanline counter. Every accepted result is compared field by
// field with the oldest pending translation.
// ----------------------------------------------------------------------------

module bmsi_map_checker
    import bmsi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_item   i_in_item,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_item  i_out_item,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_data,
    output int         o_mismatches,
    output int         o_outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    logic [5:0] bank_count;
    logic [7:0] bank_ctrl;
    logic [7:0] bank_data [NUM_BANKS];
    logic       mirror;
    logic [7:0] ram_protect;
    logic [7:0] irq_reload;
    logic [7:0] irq_count;
    logic       irq_enabled;
    logic [3:0] a12_run;

    t_out_item  pending_xlat [$];

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        o_mismatches++;
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                 want);
    endtask

    task automatic reset_model();
        bank_count  = PRG_BANK_COUNT_RST;
        bank_ctrl   = '0;
        for (int i = 0; i < NUM_BANKS; i++) begin
            bank_data[i] = '0;
        end
        mirror      = 1'b0;
        ram_protect = '0;
        irq_reload  = '0;
        irq_count   = '0;
        irq_enabled = 1'b0;
        a12_run     = '0;
    endtask

    task automatic register_write(input logic [15:0] a, input logic [7:0] v);
        logic [2:0] idx;
        idx = bank_ctrl[2:0];
        case (t_wr_group'(a[14:13]))
            WR_BANK: begin
                if (!a[0]) begin
                    bank_ctrl = v;
                end else begin
                    if (idx < 3'd2) begin
                        v = v & 8'hfe;
                    end else if (idx > 3'd5) begin
                        v = v & 8'h3f;
                    end
                    bank_data[idx] = v;
                end
            end
            WR_MIRROR: begin
                if (!a[0]) begin
                    mirror = v[0];
                end else begin
                    ram_protect = v;
                end
            end
            WR_IRQ: begin
                if (!a[0]) begin
                    irq_reload = v;
                end else begin
                    irq_count = '0;
                end
            end
            WR_ENABLE: begin
                irq_enabled = a[0];
            end
            default: begin
            end
        endcase
    endtask

    function automatic logic [MAP_ADDR_W-1:0] prg_rom_offset(input logic [15:0] a);
        logic [1:0]  win;
        logic [5:0]  last_bank;
        logic [5:0]  second_last;
        logic [7:0]  bank;
        logic [31:0] off;
        win         = a[14:13];
        last_bank   = {bank_count[4:0], 1'b0} - 6'd1;
        second_last = {bank_count[4:0], 1'b0} - 6'd2;
        if (win == 2'd1) begin
            bank = bank_data[7];
        end else if (win == 2'd3) begin
            bank = {2'b00, last_bank};
        end else if ((win == 2'd0) == (bank_ctrl[6] == 1'b0)) begin
            bank = bank_data[6];
        end else begin
            bank = {2'b00, second_last};
        end
        off = (32'(bank) << 13) + 32'(a[12:0]);
        off = off & ((32'd1 << PRG_ADDR_BITS_DEF) - 32'd1);
        return off[MAP_ADDR_W-1:0];
    endfunction

    function automatic logic [MAP_ADDR_W-1:0] chr_rom_offset(input logic [15:0] a);
        logic [12:0] w;
        logic [31:0] off;
        w = a[12:0];
        if (bank_ctrl[7]) begin
            w = w ^ 13'h1000;
        end
        if (!w[12]) begin
            off = 32'(bank_data[w[11]] & 8'hfe) * 32'h400 + 32'(w[10:0]);
        end else begin
            off = 32'(bank_data[3'd2 + {1'b0, w[11:10]}]) * 32'h400 + 32'(w[9:0]);
        end
        off = off & ((32'd1 << CHR_ADDR_BITS_DEF) - 32'd1);
        return off[MAP_ADDR_W-1:0];
    endfunction

    task automatic translate_access(input t_in_item it, output t_out_item res);
        t_action    act;
        logic [15:0] a;
        act = t_action'(it.action);
        a   = it.address;
        res = '0;
        case (act)
            ACT_CPU_WRITE, ACT_CPU_READ: begin
                if (a >= 16'h6000 && a < 16'h8000) begin
                    res.region         = REG_PRG_RAM;
                    res.mapped_address = MAP_ADDR_W'(a & 16'h1fff);
                end else if (act == ACT_CPU_WRITE) begin
                    if (a[15]) begin
                        register_write(a, it.value);
                    end
                end else if (a[15]) begin
                    res.region         = REG_PRG_ROM;
                    res.mapped_address = prg_rom_offset(a);
                end
            end
            ACT_PPU_TICK: begin
                if (!a[13]) begin
                    res.region         = REG_CHR_ROM;
                    res.mapped_address = chr_rom_offset(a);
                end
                if (!a[12]) begin
                    if (a12_run < A12_RUN_MAX) begin
                        a12_run = a12_run + 4'd1;
                    end
                end else begin
                    if (a12_run >= A12_FILTER_MIN) begin
                        if (irq_count == 8'd0) begin
                            irq_count = irq_reload;
                        end else begin
                            irq_count = irq_count - 8'd1;
                        end
                        res.irq_pulse = (irq_count == 8'd0) && irq_enabled;
                    end
                    a12_run = '0;
                end
            end
            default: begin
            end
        endcase
        res.mirror_horizontal = mirror;
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            reset_model();
            pending_xlat.delete();
        end else begin
            if (i_cfg_we) begin
                bank_count = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_item;
                if (pending_xlat.size() == 0) begin
                    report_mismatch("item with nothing expected", int'(got), 0);
                end else begin
                    want = pending_xlat.pop_front();
                    if (got.region !== want.region) begin
                        report_mismatch("region", int'(got.region), int'(want.region));
                    end
                    if (got.mapped_address !== want.mapped_address) begin
                        report_mismatch("mapped_address", int'(got.mapped_address),
                                        int'(want.mapped_address));
                    end
                    if (got.irq_pulse !== want.irq_pulse) begin
                        report_mismatch("irq_pulse", int'(got.irq_pulse),
                                        int'(want.irq_pulse));
                    end
                    if (got.mirror_horizontal !== want.mirror_horizontal) begin
                        report_mismatch("mirror_horizontal", int'(got.mirror_horizontal),
                                        int'(want.mirror_horizontal));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                translate_access(i_in_item, want);
                pending_xlat.push_back(want);
            end
        end
        o_outstanding = pending_xlat.size();
    end

endmodule

// ===== sim/tb_bank_mapper_with_scanline_irq_core.sv =====
// ----------------------------------------------------------------------------
// tb_bank_mapper_with_scanline_irq_core
// Drives CPU writes, CPU reads and PPU ticks into the bank mapper under bursty
// input and a stalling output, with one long output hold-off. The program
// bank count is changed between phases while the mapper is idle. A separate
// checker predicts every result; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------

module tb_bank_mapper_with_scanline_irq_core
    import bmsi_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 165;
    localparam int NUM_PHASES      = 6;
    localparam int STALL_LIMIT     = 3000;
    localparam int HOLD_CYCLES     = 300;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in_item   in_item;
    logic       out_valid;
    logic       out_ready;
    t_out_item  out_item;
    logic       cfg_we;
    logic [5:0] cfg_data;

    int         mismatches;
    int         outstanding;
    int         items_sent;
    int         burst_left;
    bit         steady;
    bit         hold_req;
    int         idle_cycles;

    bank_mapper_with_scanline_irq_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    bmsi_map_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_item    (out_item),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_bank_mapper_with_scanline_irq_core failed");
                $finish;
            end
        end
    end

    initial begin : result_drain
        int mode;
        int len;
        int held;
        out_ready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(10, 120);
            repeat (len) begin
                @(posedge clk);
                if (hold_req) begin
                    hold_req = 1'b0;
                    out_ready <= 1'b0;
                    held = 0;
                    while (held < HOLD_CYCLES) begin
                        @(posedge clk);
                        held++;
                    end
                end
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ~out_ready;
                endcase
            end
        end
    end

    function automatic t_in_item access(input t_action act, input logic [15:0] a,
                                        input logic [7:0] v);
        t_in_item it;
        it.action  = act;
        it.address = a;
        it.value   = v;
        return it;
    endfunction

    task automatic send(input t_in_item it);
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        items_sent++;
        if (!steady) begin
            if (burst_left == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                         : $urandom_range(0, 20);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic write_bank_count(input logic [5:0] count);
        wait_idle();
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= count;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic scanline(input int lows, input logic [15:0] low_a, input logic [15:0] high_a);
        repeat (lows) send(access(ACT_PPU_TICK, low_a, 8'h00));
        send(access(ACT_PPU_TICK, high_a, 8'h00));
    endtask

    task automatic run_directed();
        send(access(ACT_CPU_READ, 16'h0000, 8'h00));
        send(access(ACT_CPU_WRITE, 16'h5fff, 8'hff));
        send(access(ACT_CPU_READ, 16'h6000, 8'h00));
        send(access(ACT_CPU_WRITE, 16'h7fff, 8'haa));
        send(access(ACT_CPU_READ, 16'h8000, 8'h00));
        send(access(ACT_CPU_READ, 16'hffff, 8'h00));
        send(access(ACT_CPU_WRITE, 16'h8000, 8'h00));
        send(access(ACT_CPU_WRITE, 16'h8001, 8'hff));
        send(access(ACT_CPU_WRITE, 16'h8000, 8'h47));
        send(access(ACT_CPU_WRITE, 16'h9fff, 8'hff));
        send(access(ACT_CPU_WRITE, 16'h8000, 8'h86));
        send(access(ACT_CPU_WRITE, 16'h8001, 8'hff));
        send(access(ACT_CPU_READ, 16'h8000, 8'h00));
        send(access(ACT_CPU_READ, 16'hc000, 8'h00));
        send(access(ACT_PPU_TICK, 16'h1fff, 8'h00));
        send(access(ACT_PPU_TICK, 16'hffff, 8'h00));
        send(access(ACT_CPU_WRITE, 16'ha000, 8'h01));
        send(access(ACT_CPU_WRITE, 16'ha001, 8'hff));
        send(access(ACT_CPU_WRITE, 16'hc000, 8'h01));
        send(access(ACT_CPU_WRITE, 16'hc001, 8'h00));
        send(access(ACT_CPU_WRITE, 16'he001, 8'h00));
        scanline(9, 16'h0000, 16'h1000);
        scanline(16, 16'h2000, 16'h1000);
        scanline(3, 16'h0000, 16'h1000);
        send(access(ACT_NONE, 16'hffff, 8'hff));
        send(access(ACT_CPU_WRITE, 16'he000, 8'h00));
    endtask

    task automatic random_sequence();
        int          kind;
        logic [15:0] a;
        logic [15:0] b;
        logic [7:0]  v;
        logic [1:0]  act;
        a    = 16'($urandom);
        b    = 16'($urandom);
        v    = 8'($urandom);
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
            send(access(ACT_CPU_WRITE, {3'b100, a[12:1], 1'b0}, v));
            v = 8'($urandom);
            send(access(ACT_CPU_WRITE, {3'b100, b[12:1], 1'b1}, v));
        end else if (kind < 28) begin
            send(access(ACT_CPU_WRITE, {3'b101, a[12:0]}, v));
        end else if (kind < 40) begin
            case ($urandom_range(0, 3))
                0: send(access(ACT_CPU_WRITE, {3'b110, a[12:1], 1'b0},
                               ($urandom_range(0, 3) == 0) ? v : 8'($urandom_range(0, 5))));
                1: send(access(ACT_CPU_WRITE, {3'b110, a[12:1], 1'b1}, v));
                2: send(access(ACT_CPU_WRITE, {3'b111, a[12:1], 1'b0}, v));
                default: send(access(ACT_CPU_WRITE, {3'b111, a[12:1], 1'b1}, v));
            endcase
        end else if (kind < 65) begin
            a[12] = 1'b0;
            b[12] = 1'b1;
            if ($urandom_range(0, 3) != 0) begin
                a[15:13] = 3'b000;
                b[15:13] = 3'b000;
            end
            scanline($urandom_range(0, 16), a, b);
        end else if (kind < 75) begin
            send(access(ACT_PPU_TICK, a, v));
        end else if (kind < 90) begin
            if ($urandom_range(0, 4) != 0) begin
                a[15] = 1'b1;
            end
            send(access(ACT_CPU_READ, a, v));
        end else begin
            act = 2'($urandom);
            send(access(t_action'(act), a, v));
        end
    endtask

    initial begin : stimulus
        logic [5:0] counts [NUM_PHASES];
        in_valid <= 1'b0;
        in_item  <= '0;
        cfg_we   <= 1'b0;
        cfg_data <= '0;
        rst_n    <= 1'b0;
        items_sent  = 0;
        burst_left  = 0;
        steady      = 1'b0;
        hold_req    = 1'b0;
        idle_cycles = 0;
        counts = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd2, 6'd2};
        counts[4] = 6'($urandom_range(1, 32));
        counts[5] = 6'($urandom_range(0, 63));
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        items_sent = 0;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            write_bank_count(counts[phase]);
            if (phase == 1) begin
                hold_req = 1'b1;
                steady   = 1'b1;
                repeat (40) send(access(ACT_CPU_READ, 16'($urandom_range(16'h8000, 16'hffff)),
                                        8'h00));
                steady   = 1'b0;
            end
            while (items_sent < ITEMS_PER_PHASE * (phase + 1)) begin
                random_sequence();
            end
        end
        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_bank_mapper_with_scanline_irq_core passed");
        end else begin
            $display("tb_bank_mapper_with_scanline_irq_core failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/bmsi_pkg.sv
rtl/core/bmsi_regs.sv
rtl/core/bmsi_xlate.sv
rtl/core/bank_mapper_with_scanline_irq_core.sv
sim/bmsi_map_checker.sv
sim/tb_bank_mapper_with_scanline_irq_core.sv
